[sv/dtk_pkg.sv]
package dtk_pkg;

    localparam int unsigned HOUR_W      = 7;
    localparam int unsigned MINUTE_W    = 7;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned REAL_HOUR_W = 5;
    localparam int unsigned REAL_MIN_W  = 6;
    localparam int unsigned MS_W        = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = MINUTE_W'(60);
    localparam logic [HOUR_W-1:0]   HOURS_PER_DAY    = HOUR_W'(24);
    localparam logic [HOUR_W-1:0]   HOUR_ELEVEN      = HOUR_W'(11);
    localparam logic [HOUR_W-1:0]   HOUR_TWELVE      = HOUR_W'(12);
    localparam logic [HOUR_W-1:0]   HOUR_ONE         = HOUR_W'(1);
    localparam logic [HOUR_W-1:0]   HOUR_WRAP        = HOUR_W'(100);
    localparam logic [DIGIT_W-1:0]  DIGIT_MAX        = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0]  DIGIT_BASE       = DIGIT_W'(10);

    localparam logic            USE_24_HOUR_RESET = 1'b0;
    localparam logic [MS_W-1:0] TIMEOUT_RESET     = MS_W'(10000);

    typedef enum logic [1:0] {
        OP_SYNC     = 2'd0,
        OP_ADVANCE  = 2'd1,
        OP_SET      = 2'd2,
        OP_MAINTAIN = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USE_24_HOUR = 1'd0,
        REG_TIMEOUT     = 1'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DIG_HOUR_TENS   = 3'd0,
        DIG_HOUR_ONES   = 3'd1,
        DIG_NONE        = 3'd2,
        DIG_MINUTE_TENS = 3'd3,
        DIG_MINUTE_ONES = 3'd4
    } digit_pos_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } digits_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic              pm;
    } shown_hour_t;

    // Split 0..99 into decimal digits: x*205 >> 11 equals x/10 over that range.
    function automatic digits_t split_digits(input logic [6:0] x);
        logic [14:0]        prod;
        logic [DIGIT_W-1:0] tens;
        logic [7:0]         back;
        digits_t            d;
        prod   = 15'(x) * 15'd205;
        tens   = prod[14:11];
        back   = 8'(tens) * 8'(DIGIT_BASE);
        d.tens = tens;
        d.ones = DIGIT_W'(8'(x) - back);
        return d;
    endfunction

    // Reduce 0..100 modulo 24.
    function automatic logic [HOUR_W-1:0] mod_day(input logic [HOUR_W-1:0] x);
        logic [HOUR_W-1:0] r;
        if (x >= HOUR_W'(96))
            r = x - HOUR_W'(96);
        else if (x >= HOUR_W'(72))
            r = x - HOUR_W'(72);
        else if (x >= HOUR_W'(48))
            r = x - HOUR_W'(48);
        else if (x >= HOURS_PER_DAY)
            r = x - HOURS_PER_DAY;
        else
            r = x;
        return r;
    endfunction

    // True hour as shown: unchanged in 24-hour mode, else 1..12.
    function automatic shown_hour_t format_hour(input logic [REAL_HOUR_W-1:0] h24,
                                                input logic use_24);
        logic [HOUR_W-1:0] h;
        logic [HOUR_W-1:0] r;
        shown_hour_t       s;
        h = HOUR_W'(h24);
        if (h >= HOURS_PER_DAY)
            r = h - HOURS_PER_DAY;
        else if (h >= HOUR_TWELVE)
            r = h - HOUR_TWELVE;
        else
            r = h;
        s.pm = (h >= HOUR_TWELVE);
        if (use_24)
            s.hour = h;
        else
            s.hour = (r == '0) ? HOUR_TWELVE : r;
        return s;
    endfunction

endpackage

[sv/dtk_if.sv]
interface dtk_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [4:0]  real_hour;
    logic [5:0]  real_minute;
    logic [2:0]  digit_index;
    logic [3:0]  digit_value;
    logic        animation_idle;
    logic [31:0] now_ms;

    modport source (output valid, op, real_hour, real_minute, digit_index, digit_value,
                    animation_idle, now_ms, input ready);
    modport sink   (input valid, op, real_hour, real_minute, digit_index, digit_value,
                    animation_idle, now_ms, output ready);
endinterface

interface dtk_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] shown_hour;
    logic [6:0] shown_minute;
    logic       shown_pm;
    logic       override_on;
    logic       time_match;
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;

    modport source (output valid, shown_hour, shown_minute, shown_pm, override_on,
                    time_match, hour_tens, hour_ones, minute_tens, minute_ones,
                    input ready);
    modport sink   (input valid, shown_hour, shown_minute, shown_pm, override_on,
                    time_match, hour_tens, hour_ones, minute_tens, minute_ones,
                    output ready);
endinterface

[sv/displayed_time_keeper.sv]
// Displayed hour/minute/PM keeper for a clock face.
// Channel item (sink) carries one operation word: sync to a true time,
// advance one minute, set one digit, or maintain a manual override.
// Channel result (source) returns one word per item: the shown time and PM
// flag after the operation, the override flag, the match flag of a maintain
// operation and the four decimal digits of the shown time.
// The configuration port writes use_24_hour (index 0) and
// override_timeout_ms (index 1) on any edge with cfg_we high; write it only
// while no item is in flight.
// An accepted word is processed by the state update logic and its result
// is registered at the same edge. Throughput is one word per cycle while
// results are taken; the limit is the single feedback path through the time
// registers. The item channel stays ready while the result register is
// empty or being drained, so a stalled receiver holds one result and stops
// intake until it is taken.
// Reset clears the shown time, PM flag and override, selects 12-hour mode
// and a 10000 ms override timeout, and empties the result register.
module displayed_time_keeper
    import dtk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dtk_item_if.sink              item,
    dtk_result_if.source          result
);

    logic              use_24_reg;
    logic [MS_W-1:0]   timeout_reg;

    logic [HOUR_W-1:0]   hour_reg,   hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;
    logic                pm_reg,     pm_next;
    logic                override_reg, override_next;
    logic [MS_W-1:0]     start_reg,  start_next;

    logic               out_valid_reg;
    logic [HOUR_W-1:0]   out_hour_reg;
    logic [MINUTE_W-1:0] out_minute_reg;
    logic                out_pm_reg;
    logic                out_override_reg;
    logic                out_match_reg;
    digits_t             out_hour_dig_reg;
    digits_t             out_minute_dig_reg;

    logic                accept;
    logic                match;
    logic                resume_ok;
    logic                expired;
    shown_hour_t         real_fmt;
    digits_t             cur_hour_dig;
    digits_t             cur_minute_dig;
    logic [DIGIT_W-1:0]  digit_sat;
    logic [MINUTE_W-1:0] minute_inc;
    logic [HOUR_W-1:0]   hour_inc;
    logic [MS_W-1:0]     elapsed;
    op_t                 op;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign op         = op_t'(item.op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_24_reg  <= USE_24_HOUR_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_USE_24_HOUR: use_24_reg  <= cfg_data[0];
                REG_TIMEOUT:     timeout_reg <= MS_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    assign real_fmt       = format_hour(item.real_hour, use_24_reg);
    assign cur_hour_dig   = split_digits(hour_reg);
    assign cur_minute_dig = split_digits(minute_reg);
    assign digit_sat      = (item.digit_value > DIGIT_MAX) ? DIGIT_MAX : item.digit_value;
    assign minute_inc     = minute_reg + MINUTE_W'(1);
    assign hour_inc       = hour_reg + HOUR_W'(1);
    assign elapsed        = item.now_ms - start_reg;
    assign match          = (hour_reg == real_fmt.hour)
                         && (minute_reg == MINUTE_W'(item.real_minute))
                         && (pm_reg == real_fmt.pm);
    assign resume_ok      = item.animation_idle && match;
    assign expired        = (elapsed > timeout_reg);

    always_comb
    begin
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        pm_next       = pm_reg;
        override_next = override_reg;
        start_next    = start_reg;
        unique case (op)
            OP_SYNC:
            begin
                hour_next   = real_fmt.hour;
                minute_next = MINUTE_W'(item.real_minute);
                pm_next     = real_fmt.pm;
            end
            OP_ADVANCE:
            begin
                if (minute_inc < MINUTES_PER_HOUR)
                    minute_next = minute_inc;
                else
                begin
                    minute_next = '0;
                    if (use_24_reg)
                        hour_next = mod_day(hour_inc);
                    else if (hour_reg == HOUR_ELEVEN)
                    begin
                        hour_next = HOUR_TWELVE;
                        pm_next   = !pm_reg;
                    end
                    else if (hour_reg == HOUR_TWELVE)
                        hour_next = HOUR_ONE;
                    else if (hour_inc == HOUR_WRAP)
                        hour_next = '0;
                    else
                        hour_next = hour_inc;
                end
            end
            OP_SET:
            begin
                case (item.digit_index)
                    DIG_HOUR_TENS:
                        hour_next = HOUR_W'(8'(digit_sat) * 8'(DIGIT_BASE)
                                            + 8'(cur_hour_dig.ones));
                    DIG_HOUR_ONES:
                        hour_next = HOUR_W'(8'(cur_hour_dig.tens) * 8'(DIGIT_BASE)
                                            + 8'(digit_sat));
                    DIG_MINUTE_TENS:
                        minute_next = MINUTE_W'(8'(digit_sat) * 8'(DIGIT_BASE)
                                                + 8'(cur_minute_dig.ones));
                    DIG_MINUTE_ONES:
                        minute_next = MINUTE_W'(8'(cur_minute_dig.tens) * 8'(DIGIT_BASE)
                                                + 8'(digit_sat));
                    default: ;
                endcase
                // Flip PM when the edit turns 11 into 12 on a 12-hour face.
                if (!use_24_reg && hour_reg == HOUR_ELEVEN && hour_next == HOUR_TWELVE)
                    pm_next = !pm_reg;
                if (!override_reg)
                    start_next = item.now_ms;
                override_next = 1'b1;
            end
            OP_MAINTAIN:
            begin
                if (override_reg && (resume_ok || expired))
                begin
                    override_next = 1'b0;
                    // Resync only when the timeout ends the override.
                    if (!resume_ok)
                    begin
                        hour_next   = real_fmt.hour;
                        minute_next = MINUTE_W'(item.real_minute);
                        pm_next     = real_fmt.pm;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg     <= '0;
            minute_reg   <= '0;
            pm_reg       <= 1'b0;
            override_reg <= 1'b0;
            start_reg    <= '0;
        end
        else if (accept)
        begin
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            pm_reg       <= pm_next;
            override_reg <= override_next;
            start_reg    <= start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item.ready)
            out_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_hour_reg       <= hour_next;
            out_minute_reg     <= minute_next;
            out_pm_reg         <= pm_next;
            out_override_reg   <= override_next;
            out_match_reg      <= (op == OP_MAINTAIN) && match;
            out_hour_dig_reg   <= split_digits(hour_next);
            out_minute_dig_reg <= split_digits(minute_next);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.shown_hour   = out_hour_reg;
    assign result.shown_minute = out_minute_reg;
    assign result.shown_pm     = out_pm_reg;
    assign result.override_on  = out_override_reg;
    assign result.time_match   = out_match_reg;
    assign result.hour_tens    = out_hour_dig_reg.tens;
    assign result.hour_ones    = out_hour_dig_reg.ones;
    assign result.minute_tens  = out_minute_dig_reg.tens;
    assign result.minute_ones  = out_minute_dig_reg.ones;

endmodule

[bench/tb_top.sv]
module tb_top
    import dtk_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        op_t         op;
        logic [4:0]  real_hour;
        logic [5:0]  real_minute;
        logic [2:0]  digit_index;
        logic [3:0]  digit_value;
        logic        animation_idle;
        logic [31:0] now_ms;
    } clock_word_t;

    typedef struct {
        logic [6:0] hour;
        logic [6:0] minute;
        logic       pm;
        logic       override_on;
        logic       time_match;
        logic [3:0] hour_tens;
        logic [3:0] hour_ones;
        logic [3:0] minute_tens;
        logic [3:0] minute_ones;
    } face_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dtk_item_if   item_bus();
    dtk_result_if result_bus();

    displayed_time_keeper uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    // Shadow of the displayed time and override, plus the configuration
    logic [6:0]  face_hour   = '0;
    logic [6:0]  face_minute = '0;
    logic        face_pm     = 1'b0;
    logic        hold_on     = 1'b0;
    logic [31:0] hold_since  = '0;
    logic        mode_24     = USE_24_HOUR_RESET;
    logic [31:0] hold_limit  = TIMEOUT_RESET;

    clock_word_t words_to_send[$];
    face_t       faces_due[$];

    int          fault_count   = 0;
    int          words_queued  = 0;
    int          results_seen  = 0;
    int          op_counts[4]  = '{default: 0};
    int          match_count   = 0;
    int          expiry_count  = 0;
    int          release_count = 0;
    logic [31:0] now_clock     = '0;
    logic        send_calm     = 1'b0;
    logic        take_calm     = 1'b0;
    int          send_pause;
    int          take_pause;

    initial begin
        clk                       = 1'b0;
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = REG_USE_24_HOUR;
        cfg_data                  = '0;
        item_bus.valid            = 1'b0;
        item_bus.op               = OP_SYNC;
        item_bus.real_hour        = '0;
        item_bus.real_minute      = '0;
        item_bus.digit_index      = '0;
        item_bus.digit_value      = '0;
        item_bus.animation_idle   = 1'b0;
        item_bus.now_ms           = '0;
        result_bus.ready          = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        fault_count++;
        if (fault_count <= 50)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // True time as it would be shown in the current mode
    function automatic void true_face(input logic [4:0] h24, input logic [5:0] m,
                                      output logic [6:0] hr, output logic [6:0] mn,
                                      output logic pm);
        int h;
        hr = 7'(h24);
        mn = 7'(m);
        pm = (7'(h24) >= HOUR_TWELVE);
        if (!mode_24) begin
            h  = int'(h24) % 12;
            hr = (h == 0) ? HOUR_TWELVE : 7'(h);
        end
    endfunction

    function automatic face_t predict_face(input clock_word_t w);
        logic [6:0] th;
        logic [6:0] tm;
        logic       tp;
        logic [6:0] old_hour;
        logic       hit;
        logic       idle_hit;
        logic       expired;
        int         v;
        face_t      f;
        hit = 1'b0;
        op_counts[w.op]++;
        case (w.op)
            OP_SYNC:
                true_face(w.real_hour, w.real_minute, face_hour, face_minute, face_pm);
            OP_ADVANCE:
            begin
                face_minute = face_minute + 7'd1;
                if (face_minute >= MINUTES_PER_HOUR) begin
                    face_minute = '0;
                    if (mode_24)
                        face_hour = 7'((int'(face_hour) + 1) % 24);
                    else if (face_hour == HOUR_ELEVEN) begin
                        face_hour = HOUR_TWELVE;
                        face_pm   = ~face_pm;
                    end else if (face_hour == HOUR_TWELVE)
                        face_hour = HOUR_ONE;
                    else
                        face_hour = 7'((int'(face_hour) + 1) % 100);
                end
            end
            OP_SET:
            begin
                v        = (w.digit_value > 4'd9) ? 9 : int'(w.digit_value);
                old_hour = face_hour;
                case (w.digit_index)
                    DIG_HOUR_TENS:   face_hour   = 7'(v * 10 + face_hour % 10);
                    DIG_HOUR_ONES:   face_hour   = 7'((face_hour / 10) * 10 + v);
                    DIG_MINUTE_TENS: face_minute = 7'(v * 10 + face_minute % 10);
                    DIG_MINUTE_ONES: face_minute = 7'((face_minute / 10) * 10 + v);
                    default: ;
                endcase
                if (!mode_24 && old_hour == HOUR_ELEVEN && face_hour == HOUR_TWELVE)
                    face_pm = ~face_pm;
                if (!hold_on)
                    hold_since = w.now_ms;
                hold_on = 1'b1;
            end
            default:
            begin
                true_face(w.real_hour, w.real_minute, th, tm, tp);
                hit = (face_hour == th && face_minute == tm && face_pm == tp);
                if (hit)
                    match_count++;
                if (hold_on) begin
                    idle_hit = w.animation_idle && hit;
                    // elapsed time wraps modulo 2^32
                    expired  = (w.now_ms - hold_since) > hold_limit;
                    if (idle_hit || expired) begin
                        hold_on = 1'b0;
                        if (!idle_hit) begin
                            expiry_count++;
                            true_face(w.real_hour, w.real_minute,
                                      face_hour, face_minute, face_pm);
                        end else
                            release_count++;
                    end
                end
            end
        endcase
        f.hour        = face_hour;
        f.minute      = face_minute;
        f.pm          = face_pm;
        f.override_on = hold_on;
        f.time_match  = hit;
        f.hour_tens   = 4'(face_hour / 10);
        f.hour_ones   = 4'(face_hour % 10);
        f.minute_tens = 4'(face_minute / 10);
        f.minute_ones = 4'(face_minute % 10);
        return f;
    endfunction

    // Sender: predict on each accepted word, then present the next one
    always @(posedge clk or negedge rst_n) begin : send_side
        clock_word_t w;
        if (!rst_n) begin
            item_bus.valid <= 1'b0;
            send_pause     <= 0;
        end else begin
            if (item_bus.valid && item_bus.ready) begin
                w.op             = op_t'(item_bus.op);
                w.real_hour      = item_bus.real_hour;
                w.real_minute    = item_bus.real_minute;
                w.digit_index    = item_bus.digit_index;
                w.digit_value    = item_bus.digit_value;
                w.animation_idle = item_bus.animation_idle;
                w.now_ms         = item_bus.now_ms;
                faces_due.push_back(predict_face(w));
            end
            if (!item_bus.valid || item_bus.ready) begin
                if (send_pause != 0 || words_to_send.size() == 0) begin
                    item_bus.valid <= 1'b0;
                    if (send_pause != 0)
                        send_pause <= send_pause - 1;
                end else begin
                    w = words_to_send.pop_front();
                    item_bus.valid          <= 1'b1;
                    item_bus.op             <= w.op;
                    item_bus.real_hour      <= w.real_hour;
                    item_bus.real_minute    <= w.real_minute;
                    item_bus.digit_index    <= w.digit_index;
                    item_bus.digit_value    <= w.digit_value;
                    item_bus.animation_idle <= w.animation_idle;
                    item_bus.now_ms         <= w.now_ms;
                    send_pause <= send_calm ? 0 : $urandom_range(0, 3);
                end
            end
        end
    end

    // Receiver: check each accepted result, then stall for a drawn number of cycles
    always @(posedge clk or negedge rst_n) begin : take_side
        face_t want;
        int    pause;
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            take_pause       <= 0;
        end else if (result_bus.valid && result_bus.ready) begin
            results_seen++;
            if (faces_due.size() == 0)
                flag_mismatch("result word with nothing expected");
            else begin
                want = faces_due.pop_front();
                check_field("shown_hour",   result_bus.shown_hour,   want.hour);
                check_field("shown_minute", result_bus.shown_minute, want.minute);
                check_field("shown_pm",     result_bus.shown_pm,     want.pm);
                check_field("override_on",  result_bus.override_on,  want.override_on);
                check_field("time_match",   result_bus.time_match,   want.time_match);
                check_field("hour_tens",    result_bus.hour_tens,    want.hour_tens);
                check_field("hour_ones",    result_bus.hour_ones,    want.hour_ones);
                check_field("minute_tens",  result_bus.minute_tens,  want.minute_tens);
                check_field("minute_ones",  result_bus.minute_ones,  want.minute_ones);
            end
            pause = take_calm ? 0 : $urandom_range(0, 3);
            take_pause       <= pause;
            result_bus.ready <= (pause == 0);
        end else if (take_pause != 0) begin
            take_pause       <= take_pause - 1;
            result_bus.ready <= (take_pause == 1);
        end else
            result_bus.ready <= 1'b1;
    end

    task automatic write_reg(input cfg_reg_t which, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (which == REG_USE_24_HOUR)
            mode_24 = value[0];
        else
            hold_limit = value;
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || item_bus.valid || faces_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_word(input clock_word_t w);
        words_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic queue_word(input op_t op, input int rh, input int rm, input int idx,
                              input int val, input int idle, input logic [31:0] now);
        clock_word_t w;
        w.op             = op;
        w.real_hour      = 5'(rh);
        w.real_minute    = 6'(rm);
        w.digit_index    = 3'(idx);
        w.digit_value    = 4'(val);
        w.animation_idle = 1'(idle);
        w.now_ms         = now;
        send_word(w);
    endtask

    function automatic logic [31:0] next_now();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            now_clock = $urandom;
        else if (pick < 3)
            now_clock = now_clock + $urandom_range(0, 20000);
        else
            now_clock = now_clock + $urandom_range(0, 3000);
        return now_clock;
    endfunction

    // Lean toward the rollover hours and minute 59
    function automatic int pick_hour();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return (pick == 0) ? 11 : (($urandom_range(0, 1) == 0) ? 12 : 23);
        else if (pick < 8)
            return $urandom_range(0, 23);
        return $urandom_range(0, 31);
    endfunction

    function automatic int pick_minute();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return 59;
        else if (pick < 8)
            return $urandom_range(0, 59);
        return $urandom_range(0, 63);
    endfunction

    function automatic clock_word_t random_word(input op_t op);
        clock_word_t w;
        w.op             = op;
        w.real_hour      = 5'($urandom_range(0, 31));
        w.real_minute    = 6'($urandom_range(0, 63));
        w.digit_index    = 3'($urandom_range(0, 7));
        w.digit_value    = 4'($urandom_range(0, 15));
        w.animation_idle = 1'($urandom_range(0, 1));
        w.now_ms         = next_now();
        return w;
    endfunction

    // Sync to a true time, disturb it, then try to hand control back
    task automatic queue_episode();
        clock_word_t w;
        int          h;
        int          m;
        h           = pick_hour();
        m           = pick_minute();
        w           = random_word(OP_SYNC);
        w.real_hour   = 5'(h);
        w.real_minute = 6'(m);
        send_word(w);
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 2) == 0)
                send_word(random_word(OP_ADVANCE));
            else
                send_word(random_word(OP_SET));
        end
        repeat ($urandom_range(1, 3)) begin
            w             = random_word(OP_MAINTAIN);
            w.real_hour   = 5'(h);
            w.real_minute = 6'(m);
            send_word(w);
        end
    endtask

    initial begin : stimulus
        logic        phase_24[6];
        logic [31:0] phase_limit[6];
        int          target;
        phase_24    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        phase_limit = '{32'd3000, 32'd0, 32'hFFFF_FFFF, 32'd2500, $urandom, 32'd10000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_calm = 1'b1;
        take_calm = 1'b0;

        // 12-hour mode, reset timeout
        queue_word(OP_SYNC, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_SYNC, 23, 59, 0, 0, 0, 32'd0);
        queue_word(OP_ADVANCE, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_SYNC, 12, 59, 0, 0, 0, 32'd0);
        queue_word(OP_ADVANCE, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_SYNC, 31, 63, 0, 0, 0, 32'd0);
        queue_word(OP_ADVANCE, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_SET, 0, 0, DIG_HOUR_TENS, 15, 0, 32'hFFFF_FFF0);
        queue_word(OP_SET, 0, 0, DIG_HOUR_ONES, 9, 0, 32'd5);
        queue_word(OP_SET, 0, 0, DIG_MINUTE_TENS, 5, 0, 32'd5);
        queue_word(OP_SET, 0, 0, DIG_MINUTE_ONES, 12, 0, 32'd5);
        queue_word(OP_ADVANCE, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_MAINTAIN, 0, 0, 0, 0, 1, 32'd100);
        queue_word(OP_MAINTAIN, 14, 30, 0, 0, 0, 32'hFFFF_FFF0 + 32'd10000);
        queue_word(OP_MAINTAIN, 14, 30, 0, 0, 0, 32'hFFFF_FFF0 + 32'd10001);
        queue_word(OP_SYNC, 10, 59, 0, 0, 0, 32'd0);
        queue_word(OP_SET, 0, 0, DIG_HOUR_ONES, 1, 0, 32'd1000);
        queue_word(OP_SET, 0, 0, DIG_HOUR_ONES, 2, 0, 32'd1200);
        queue_word(OP_SET, 0, 0, DIG_NONE, 3, 0, 32'd1300);
        queue_word(OP_MAINTAIN, 12, 59, 0, 0, 0, 32'd1500);
        queue_word(OP_MAINTAIN, 12, 59, 0, 0, 1, 32'd1600);
        queue_word(OP_MAINTAIN, 3, 0, 0, 0, 1, 32'd1700);
        wait_drained();

        // 24-hour mode, zero timeout
        write_reg(REG_USE_24_HOUR, 32'd1);
        write_reg(REG_TIMEOUT, 32'd0);
        queue_word(OP_SYNC, 31, 63, 0, 0, 0, 32'd0);
        queue_word(OP_ADVANCE, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_SET, 0, 0, DIG_HOUR_TENS, 9, 0, 32'd7);
        queue_word(OP_SET, 0, 0, DIG_MINUTE_TENS, 5, 0, 32'd7);
        queue_word(OP_SET, 0, 0, DIG_MINUTE_ONES, 9, 0, 32'd7);
        queue_word(OP_ADVANCE, 0, 0, 0, 0, 0, 32'd0);
        queue_word(OP_MAINTAIN, 11, 0, 0, 0, 0, 32'd7);
        queue_word(OP_MAINTAIN, 11, 0, 0, 0, 0, 32'd8);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_USE_24_HOUR, 32'(phase_24[phase]));
            write_reg(REG_TIMEOUT, phase_limit[phase]);
            for (int part = 0; part < 2; part++) begin
                // one half of each phase runs the sender back to back
                send_calm = (part == 1);
                take_calm = ((phase % 2) == part);
                target    = words_queued + 110;
                while (words_queued < target) begin
                    if ($urandom_range(0, 3) != 0)
                        queue_episode();
                    else
                        send_word(random_word(op_t'($urandom_range(0, 3))));
                end
                while (words_to_send.size() != 0)
                    @(posedge clk);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d words: %0d sync, %0d advance, %0d set, %0d maintain; %0d results",
                 words_queued, op_counts[OP_SYNC], op_counts[OP_ADVANCE],
                 op_counts[OP_SET], op_counts[OP_MAINTAIN], results_seen);
        $display("Maintain saw %0d time matches, %0d timeout resyncs, %0d idle releases",
                 match_count, expiry_count, release_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
